// ===== src/nfps_pkg.sv =====
// ---------------------------------------------------------------------------
// nfps_pkg: shared types and constants for the power-shaped notch filter
// Item structs, datapath widths and the elaboration-time coefficient tables.
// ---------------------------------------------------------------------------
package nfps_pkg;

  localparam int SAMPLE_RATE = 48000;
  localparam int SAMPLE_BITS = 24;

  // prewarped 20 kHz cutoff angle in Q30
  localparam longint unsigned LP_THETA = 64'd3373259426 * 64'd20000 / SAMPLE_RATE;

  // shared multiplier operand, product and accumulator widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 2;

  // config register indexes
  localparam logic [2:0] REG_INPUT_GAIN      = 3'd0;
  localparam logic [2:0] REG_NOTCH_A0        = 3'd1;
  localparam logic [2:0] REG_NOTCH_A1        = 3'd2;
  localparam logic [2:0] REG_NOTCH_B2        = 3'd3;
  localparam logic [2:0] REG_SHAPE_EXPONENT  = 3'd4;
  localparam logic [2:0] REG_UNSHAPE_EXPONENT = 3'd5;
  localparam logic [2:0] REG_OUTPUT_GAIN     = 3'd6;
  localparam logic [2:0] REG_WET_MIX         = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          block_last;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          block_last_out;
  } result_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a0;
    logic signed [MUL_W-1:0] a1;
    logic signed [MUL_W-1:0] a2;
    logic signed [MUL_W-1:0] b1;
    logic signed [MUL_W-1:0] b2;
  } lp_coef_t;

  typedef logic [15:0][30:0] exp_tab_t;

  localparam logic [30:0] EXP_ONE = 31'h4000_0000;

  // integer square root, bit by bit
  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    longint unsigned rem;
    r = 0;
    rem = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // unsigned quotient by shift and subtract
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    logic [64:0]     rem;
    q = 0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      q = q << 1;
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // signed quotient, truncated toward zero
  function automatic longint sdiv64(input longint num, input longint den);
    longint unsigned q;
    q = udiv64((num < 0) ? 64'(-num) : 64'(num), (den < 0) ? 64'(-den) : 64'(den));
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // 2^(2^-k) for k = 1..16 in Q30
  function automatic exp_tab_t exp_tab_build();
    exp_tab_t t;
    longint unsigned v;
    v = isqrt64(64'd1 << 61);
    t[0] = 31'(v);
    for (int i = 1; i < 16; i++) begin
      v = isqrt64(v << 30);
      t[i] = 31'(v);
    end
    return t;
  endfunction

  // 20 kHz Butterworth lowpass coefficients in Q30
  function automatic lp_coef_t lp_coefs();
    lp_coef_t c;
    longint unsigned th;
    longint unsigned th2;
    longint unsigned ts;
    longint unsigned tc;
    longint sn;
    longint cs;
    longint k;
    longint kq;
    longint k2;
    longint d;
    longint one;
    longint fone;
    longint a0;
    one = 64'sd1 << 24;
    fone = 64'sd1 << 30;
    th = LP_THETA;
    if (th > 64'd1610612736) th = 64'd1610612736;
    th2 = (th * th) >> 30;
    ts = th;
    tc = 64'd1 << 30;
    sn = longint'(th);
    cs = fone;
    for (int i = 1; i <= 10; i++) begin
      ts = udiv64((ts * th2) >> 30, 64'((2 * i) * (2 * i + 1)));
      tc = udiv64((tc * th2) >> 30, 64'((2 * i - 1) * (2 * i)));
      if ((i & 1) == 1) begin
        sn = sn - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        sn = sn + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    if (cs < 1) cs = 1;
    if (sn < 0) sn = 0;
    k = longint'(udiv64(64'(sn) << 24, 64'(cs)));
    if (k > (64'sd1 << 28)) k = 64'sd1 << 28;
    k2 = (k * k) >>> 24;
    kq = sdiv64(k * 10000, 7071);
    d = one + kq + k2;
    a0 = sdiv64(k2 * fone, d);
    c.a0 = MUL_W'(a0);
    c.a1 = MUL_W'(2 * a0);
    c.a2 = MUL_W'(a0);
    c.b1 = MUL_W'(2 * sdiv64((k2 - one) * fone, d));
    c.b2 = MUL_W'(sdiv64((one - kq + k2) * fone, d));
    return c;
  endfunction

  localparam lp_coef_t LP_COEF = lp_coefs();
  localparam exp_tab_t EXP_TAB = exp_tab_build();

endpackage

// ===== src/nfps_mul.sv =====
// ---------------------------------------------------------------------------
// nfps_mul: shared signed multiplier
// One registered signed multiply, loaded when en is high.
// ---------------------------------------------------------------------------
module nfps_mul import nfps_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  // register the product
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ===== src/notch_filter_with_power_shaping.sv =====
// ---------------------------------------------------------------------------
// notch_filter_with_power_shaping: mono notch filter with power-law shaping
// Input gain, 20 kHz lowpass, power shaping, loadable notch, unshaping,
// output gain, second lowpass and dry/wet mix, all on one multiplier.
// ---------------------------------------------------------------------------
// One sample is taken at a time; the next is accepted only once the current
// result is loaded. The run is shorter when an exponent or shaping base is
// zero or wet_mix is 4096 or more. The time is set by the shared 33x33
// multiplier: each of the two power stages runs 16 log2 squaring steps and
// 16 exp2 steps through it, and the three biquads run through it as well.
// The finished result sits in an output register, so the next sample is
// accepted while it waits.
module notch_filter_with_power_shaping import nfps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [25:0] wr_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_GAIN_MUL, S_GAIN_RND,
    S_BQ0, S_BQ1, S_BQ2, S_BQ3, S_BQ4, S_BQ5,
    S_SHP_NORM, S_LOG_MUL, S_LOG_UPD, S_LGE_MUL, S_LGE_RND,
    S_EXP_MUL, S_EXP_UPD, S_PW_SHIFT, S_SHP_OUT,
    S_OG_MUL, S_OG_RND, S_MIX0, S_MIX1, S_MIX2, S_DONE
  } state_t;

  typedef enum logic [1:0] {FLT_PRE, FLT_NOTCH, FLT_POST} flt_t;

  state_t state;
  flt_t   fsel;
  logic   pass;

  // configuration
  logic [15:0]        input_gain;
  logic signed [25:0] notch_a0;
  logic signed [25:0] notch_a1;
  logic signed [25:0] notch_b2;
  logic [15:0]        shape_exponent;
  logic [12:0]        unshape_exponent;
  logic [12:0]        output_gain;
  logic [12:0]        wet_mix;

  // filter state
  logic signed [39:0] pre_s1, pre_s2, notch_s1, notch_s2, post_s1, post_s2;

  // datapath registers
  logic signed [SAMPLE_BITS-1:0] dry;
  logic                          last;
  logic signed [MUL_W-1:0]       x;
  logic signed [31:0]            y;
  logic signed [ACC_W-1:0]       acc;
  logic [30:0]                   mant;
  logic [4:0]                    tot;
  logic [15:0]                   lg_frac;
  logic [15:0]                   g;
  logic                          big;
  logic [5:0]                    pw_sh;
  logic [30:0]                   eacc;
  logic [23:0]                   pw;
  logic                          sgn;
  logic [3:0]                    cnt;

  // multiplier
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  nfps_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:31] == {(ACC_W-31){v[31]}}) return v[31:0];
    return v[ACC_W-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:39] == {(ACC_W-39){v[39]}}) return v[39:0];
    return v[ACC_W-1] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [MUL_W-1:0] v);
    if (v[MUL_W-1:SAMPLE_BITS-1] == {(MUL_W-SAMPLE_BITS+1){v[SAMPLE_BITS-1]}}) begin
      return v[SAMPLE_BITS-1:0];
    end
    return v[MUL_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  // coefficient and state selection for the active biquad
  logic signed [MUL_W-1:0] c0, c1, c2, d1, d2;
  logic signed [39:0]      s1_cur, s2_cur;
  logic [4:0]              shr;

  always_comb begin
    c0 = LP_COEF.a0;
    c1 = LP_COEF.a1;
    c2 = LP_COEF.a2;
    d1 = LP_COEF.b1;
    d2 = LP_COEF.b2;
    shr = 5'd30;
    s1_cur = pre_s1;
    s2_cur = pre_s2;
    case (fsel)
      FLT_NOTCH: begin
        c0 = MUL_W'(notch_a0);
        c1 = MUL_W'(notch_a1);
        c2 = MUL_W'(notch_a0);
        d1 = MUL_W'(notch_a1);
        d2 = MUL_W'(notch_b2);
        shr = 5'd23;
        s1_cur = notch_s1;
        s2_cur = notch_s2;
      end
      FLT_POST: begin
        s1_cur = post_s1;
        s2_cur = post_s2;
      end
      default: begin
        s1_cur = pre_s1;
        s2_cur = pre_s2;
      end
    endcase
  end

  // biquad arithmetic
  logic signed [ACC_W-1:0] prod_w, half, diff, diff_r, y_full, s1_full;
  logic signed [MUL_W-1:0] rnd12;

  always_comb begin
    prod_w  = ACC_W'(prod);
    half    = ACC_W'(1) <<< (shr - 5'd1);
    diff    = acc - prod_w;
    diff_r  = (diff + half) >>> shr;
    y_full  = ((prod_w + half) >>> shr) + ACC_W'(s1_cur);
    s1_full = diff_r + ACC_W'(s2_cur);
    rnd12   = MUL_W'((prod_w + ACC_W'(2048)) >>> 12);
  end

  // shaping front end: clip, magnitude, normalize
  logic [MUL_W-1:0] abs_x;
  logic [23:0]      a_mag, u;
  logic [30:0]      nm;
  logic [4:0]       ntot;
  logic [15:0]      e_cur;

  always_comb begin
    abs_x = x[MUL_W-1] ? MUL_W'(-x) : MUL_W'(x);
    a_mag = (abs_x > MUL_W'(24'h800000)) ? 24'h800000 : abs_x[23:0];
    u     = 24'h800000 - a_mag;
    e_cur = pass ? {3'd0, unshape_exponent} : shape_exponent;
    nm    = {u, 7'd0};
    ntot  = 5'd0;
    if (nm[30:15] == 16'd0) begin nm = nm << 16; ntot = ntot + 5'd16; end
    if (nm[30:23] == 8'd0)  begin nm = nm << 8;  ntot = ntot + 5'd8;  end
    if (nm[30:27] == 4'd0)  begin nm = nm << 4;  ntot = ntot + 5'd4;  end
    if (nm[30:29] == 2'd0)  begin nm = nm << 2;  ntot = ntot + 5'd2;  end
    if (nm[30] == 1'b0)     begin nm = nm << 1;  ntot = ntot + 5'd1;  end
  end

  // log2 step, exponent split and final power shift
  logic [31:0]             lt;
  logic [5:0]              lg_int;
  logic signed [21:0]      lg_full;
  logic signed [ACC_W-1:0] ex;
  logic [31:0]             neg, gneg;
  logic [32:0]             nsum;
  logic [16:0]             n;
  logic [41:0]             pw_tmp, pw_full;

  always_comb begin
    lt      = prod[61:30];
    lg_int  = 6'd0 - {1'b0, tot};
    lg_full = {lg_int, lg_frac};
    ex      = (prod_w + ACC_W'(2048)) >>> 12;
    neg     = (ex > 0) ? 32'd0 : 32'(-ex);
    gneg    = 32'd0 - neg;
    nsum    = {1'b0, neg} + 33'd65535;
    n       = nsum[32:16];
    pw_tmp  = {11'd0, eacc} + (42'd1 << (pw_sh - 6'd1));
    pw_full = pw_tmp >> pw_sh;
  end

  // multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = x;
    mul_b  = c0;
    case (state)
      S_GAIN_MUL: begin mul_a = MUL_W'(dry); mul_b = MUL_W'({1'b0, input_gain}); end
      S_BQ0:      begin mul_a = x; mul_b = c0; end
      S_BQ1:      begin mul_a = x; mul_b = c1; end
      S_BQ2:      begin mul_a = MUL_W'(y); mul_b = d1; end
      S_BQ3:      begin mul_a = x; mul_b = c2; end
      S_BQ4:      begin mul_a = MUL_W'(y); mul_b = d2; end
      S_LOG_MUL:  begin mul_a = {2'b0, mant}; mul_b = {2'b0, mant}; end
      S_LGE_MUL:  begin mul_a = MUL_W'(lg_full); mul_b = MUL_W'({1'b0, e_cur}); end
      S_EXP_MUL: begin
        mul_a = {2'b0, eacc};
        mul_b = g[4'd15 - cnt] ? {2'b0, EXP_TAB[cnt]} : {2'b0, EXP_ONE};
      end
      S_OG_MUL:   begin mul_a = x; mul_b = MUL_W'({1'b0, output_gain}); end
      S_MIX0:     begin mul_a = x; mul_b = MUL_W'({1'b0, wet_mix}); end
      S_MIX1: begin
        mul_a = MUL_W'(dry);
        mul_b = MUL_W'({1'b0, 13'd4096 - wet_mix});
      end
      default:    mul_en = 1'b0;
    endcase
  end

  assign sample_stall = (state != S_IDLE);

  // sequencer, datapath and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      fsel             <= FLT_PRE;
      pass             <= 1'b0;
      result_valid     <= 1'b0;
      input_gain       <= 16'd4096;
      notch_a0         <= 26'sd3881408;
      notch_a1         <= -26'sd7274600;
      notch_b2         <= -26'sd626629;
      shape_exponent   <= 16'd4096;
      unshape_exponent <= 13'd4096;
      output_gain      <= 13'd4096;
      wet_mix          <= 13'd4096;
      pre_s1           <= '0;
      pre_s2           <= '0;
      notch_s1         <= '0;
      notch_s2         <= '0;
      post_s1          <= '0;
      post_s2          <= '0;
    end else begin
      // take config writes
      if (wr_en) begin
        case (wr_index)
          REG_INPUT_GAIN:       input_gain       <= wr_data[15:0];
          REG_NOTCH_A0:         notch_a0         <= wr_data;
          REG_NOTCH_A1:         notch_a1         <= wr_data;
          REG_NOTCH_B2:         notch_b2         <= wr_data;
          REG_SHAPE_EXPONENT:   shape_exponent   <= wr_data[15:0];
          REG_UNSHAPE_EXPONENT: unshape_exponent <= wr_data[12:0];
          REG_OUTPUT_GAIN:      output_gain      <= wr_data[12:0];
          REG_WET_MIX:          wet_mix          <= wr_data[12:0];
          default: ;
        endcase
      end

      // drop a result once taken; the final state reloads it itself
      if (result_valid && !result_stall && state != S_DONE) result_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            dry   <= sample.in_sample;
            last  <= sample.block_last;
            state <= S_GAIN_MUL;
          end
        end
        S_GAIN_MUL: state <= S_GAIN_RND;
        S_GAIN_RND: begin
          x     <= rnd12;
          fsel  <= FLT_PRE;
          state <= S_BQ0;
        end
        S_BQ0: state <= S_BQ1;
        S_BQ1: begin
          y     <= sat32(y_full);
          state <= S_BQ2;
        end
        S_BQ2: begin
          acc   <= prod_w;
          state <= S_BQ3;
        end
        S_BQ3: begin
          case (fsel)
            FLT_NOTCH: notch_s1 <= sat40(s1_full);
            FLT_POST:  post_s1  <= sat40(s1_full);
            default:   pre_s1   <= sat40(s1_full);
          endcase
          state <= S_BQ4;
        end
        S_BQ4: begin
          acc   <= prod_w;
          state <= S_BQ5;
        end
        S_BQ5: begin
          case (fsel)
            FLT_NOTCH: notch_s2 <= sat40(diff_r);
            FLT_POST:  post_s2  <= sat40(diff_r);
            default:   pre_s2   <= sat40(diff_r);
          endcase
          x <= MUL_W'(y);
          case (fsel)
            FLT_PRE: begin
              pass  <= 1'b0;
              state <= S_SHP_NORM;
            end
            FLT_NOTCH: begin
              pass  <= 1'b1;
              state <= S_SHP_NORM;
            end
            default: state <= wet_mix[12] ? S_DONE : S_MIX0;
          endcase
        end
        S_SHP_NORM: begin
          sgn <= x[MUL_W-1];
          if (e_cur == 16'd0) begin
            pw    <= 24'h800000;
            state <= S_SHP_OUT;
          end else if (u == 24'd0) begin
            pw    <= 24'd0;
            state <= S_SHP_OUT;
          end else begin
            mant    <= nm;
            tot     <= ntot;
            lg_frac <= 16'd0;
            cnt     <= 4'd0;
            state   <= S_LOG_MUL;
          end
        end
        S_LOG_MUL: state <= S_LOG_UPD;
        S_LOG_UPD: begin
          lg_frac <= {lg_frac[14:0], lt[31]};
          mant    <= lt[31] ? lt[31:1] : lt[30:0];
          cnt     <= cnt + 4'd1;
          state   <= (cnt == 4'd15) ? S_LGE_MUL : S_LOG_MUL;
        end
        S_LGE_MUL: state <= S_LGE_RND;
        S_LGE_RND: begin
          g     <= gneg[15:0];
          big   <= (n > 17'd33);
          pw_sh <= n[5:0] + 6'd7;
          eacc  <= EXP_ONE;
          cnt   <= 4'd0;
          state <= S_EXP_MUL;
        end
        S_EXP_MUL: state <= S_EXP_UPD;
        S_EXP_UPD: begin
          eacc  <= prod[60:30] + 31'(prod[29]);
          cnt   <= cnt + 4'd1;
          state <= (cnt == 4'd15) ? S_PW_SHIFT : S_EXP_MUL;
        end
        S_PW_SHIFT: begin
          pw    <= big ? 24'd0 : pw_full[23:0];
          state <= S_SHP_OUT;
        end
        S_SHP_OUT: begin
          x <= sgn ? -MUL_W'({1'b0, 24'h800000 - pw}) : MUL_W'({1'b0, 24'h800000 - pw});
          if (pass) begin
            state <= S_OG_MUL;
          end else begin
            fsel  <= FLT_NOTCH;
            state <= S_BQ0;
          end
        end
        S_OG_MUL: state <= S_OG_RND;
        S_OG_RND: begin
          x     <= rnd12;
          fsel  <= FLT_POST;
          state <= S_BQ0;
        end
        S_MIX0: state <= S_MIX1;
        S_MIX1: begin
          acc   <= prod_w;
          state <= S_MIX2;
        end
        S_MIX2: begin
          x     <= MUL_W'((acc + prod_w + ACC_W'(2048)) >>> 12);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result.out_sample     <= sat_out(x);
            result.block_last_out <= last;
            result_valid          <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // mantissa stays normalized through the log2 loop
  a_log_norm: assert property (@(posedge clk) disable iff (rst)
    state == S_LOG_MUL |-> mant[30])
    else $error("log2 mantissa not normalized");

  // power result never exceeds one
  a_pw_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SHP_OUT |-> pw <= 24'h800000)
    else $error("power result above one");

  // a result only appears out of the final state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside final state");

  // an accepted item starts the gain step
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> state == S_GAIN_MUL)
    else $error("accepted item did not start");

  // the log2 loop hands over after sixteen steps
  a_log_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_LOG_UPD && cnt == 4'd15 |=> state == S_LGE_MUL)
    else $error("log2 loop did not end");

endmodule
